>>> sv/oems_pkg.sv
// shared constants, types and command struct of the odd-even merge sorter
`default_nettype none

package oems_pkg;

    // set size and derived widths
    localparam int ELEMENT_COUNT = 8;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = $clog2(ELEMENT_COUNT);
    localparam int CNT_W         = IDX_W + 2;
    localparam int LOG_N         = $clog2(ELEMENT_COUNT);
    localparam int LOG_W         = $clog2(LOG_N + 1);

    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(ELEMENT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENT_COUNT - 1);
    localparam logic [LOG_W-1:0] LOG_N_L  = LOG_W'(LOG_N);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_CMP,
        S_WRB,
        S_EMIT
    } t_state;

    // write data source of the element ram
    typedef enum logic [1:0] {
        WR_LOAD,
        WR_MIN,
        WR_MAX
    } t_wr_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic             wr_en;
        t_wr_sel          wr_sel;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr_a;
        logic [IDX_W-1:0] rd_addr_b;
        logic             emit;
        logic             emit_last;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> sv/oems_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none

module oems_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

>>> sv/oems_datapath.sv
// datapath: element ram, compare-exchange unit and output registers
`default_nettype none

module oems_datapath
    import oems_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic signed [DATA_W-1:0] i_value_in,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_value_out,
    output logic                          o_last_out
);

    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] r_max;
    logic              swap;
    logic              r_valid;
    logic              r_last;

    oems_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ELEMENT_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.wr_en),
        .i_waddr   (i_cmd.wr_addr),
        .i_wdata   (wdata),
        .i_raddr_a (i_cmd.rd_addr_a),
        .i_raddr_b (i_cmd.rd_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // lower position holds strictly greater value
    assign swap = $signed(rd_a) > $signed(rd_b);

    // write data select
    always_comb begin
        case (i_cmd.wr_sel)
            WR_LOAD: wdata = i_value_in;
            WR_MIN:  wdata = swap ? rd_b : rd_a;
            WR_MAX:  wdata = r_max;
            default: wdata = i_value_in;
        endcase
    end

    // hold the larger value for the second write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sel == WR_MIN) begin
            r_max <= swap ? rd_a : rd_b;
        end
    end

    // output strobe registered to line up with the registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            r_last  <= i_cmd.emit_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_last_out  = r_last;
    assign o_value_out = rd_a;

endmodule

`default_nettype wire

>>> sv/oems_ctrl.sv
// controller: load count, sorting network sequencer and emission counter
`default_nettype none

module oems_ctrl
    import oems_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output t_dp_cmd   o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_load,  n_load;
    logic [IDX_W-1:0] r_emit,  n_emit;
    logic [CNT_W-1:0] r_i,     n_i;
    logic [CNT_W-1:0] r_j,     n_j;
    logic [LOG_W-1:0] r_lk,    n_lk;
    logic [LOG_W-1:0] r_lp,    n_lp;

    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    logic [CNT_W-1:0] i1;
    logic [CNT_W-1:0] j2;
    logic [LOG_W-1:0] sh;
    logic [LOG_W-1:0] lp1;
    logic             pair_ok;

    logic [CNT_W-1:0] adv_i;
    logic [CNT_W-1:0] adv_j;
    logic [LOG_W-1:0] adv_lk;
    logic [LOG_W-1:0] adv_lp;
    logic             adv_done;

    // current comparator candidate
    assign k   = CNT_W'(1) << r_lk;
    assign a   = r_i + r_j;
    assign b   = a + k;
    assign lp1 = r_lp + LOG_W'(1);
    assign sh  = lp1;
    assign pair_ok = (b < N_CNT) && ((a >> sh) == (b >> sh));

    // next candidate of the merge network
    assign i1 = r_i + CNT_W'(1);
    assign j2 = r_j + (k << 1);

    always_comb begin
        adv_i    = '0;
        adv_j    = r_j;
        adv_lk   = r_lk;
        adv_lp   = r_lp;
        adv_done = 1'b0;
        if ((i1 < k) && ((i1 + r_j + k) < N_CNT)) begin
            adv_i = i1;
        end else if ((j2 + k) < N_CNT) begin
            adv_j = j2;
        end else if (r_lk != '0) begin
            // halve the distance; start offset is the new distance
            adv_lk = r_lk - LOG_W'(1);
            adv_j  = k >> 1;
        end else if (lp1 < LOG_N_L) begin
            // next run size, distance equal to it, start offset zero
            adv_lp = lp1;
            adv_lk = lp1;
            adv_j  = '0;
        end else begin
            adv_done = 1'b1;
        end
    end

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load  <= '0;
            r_emit  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_lk    <= '0;
            r_lp    <= '0;
        end else begin
            r_state <= n_state;
            r_load  <= n_load;
            r_emit  <= n_emit;
            r_i     <= n_i;
            r_j     <= n_j;
            r_lk    <= n_lk;
            r_lp    <= n_lp;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_load          = r_load;
        n_emit          = r_emit;
        n_i             = r_i;
        n_j             = r_j;
        n_lk            = r_lk;
        n_lp            = r_lp;
        busy            = (r_state != S_IDLE);
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_sel    = WR_LOAD;
        o_cmd.wr_addr   = r_load;
        o_cmd.rd_addr_a = a[IDX_W-1:0];
        o_cmd.rd_addr_b = b[IDX_W-1:0];
        o_cmd.emit      = 1'b0;
        o_cmd.emit_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.wr_en = 1'b1;
                    if (r_load == LAST_IDX) begin
                        n_load  = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_lk    = '0;
                        n_lp    = '0;
                        n_state = S_CHECK;
                    end else begin
                        n_load = r_load + IDX_W'(1);
                    end
                end
            end
            S_CHECK: begin
                if (pair_ok) begin
                    n_state = S_READ;
                end else begin
                    n_i     = adv_i;
                    n_j     = adv_j;
                    n_lk    = adv_lk;
                    n_lp    = adv_lp;
                    n_state = adv_done ? S_EMIT : S_CHECK;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_MIN;
                o_cmd.wr_addr = a[IDX_W-1:0];
                n_state       = S_WRB;
            end
            S_WRB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_MAX;
                o_cmd.wr_addr = b[IDX_W-1:0];
                n_i           = adv_i;
                n_j           = adv_j;
                n_lk          = adv_lk;
                n_lp          = adv_lp;
                n_state       = adv_done ? S_EMIT : S_CHECK;
            end
            S_EMIT: begin
                o_cmd.rd_addr_a = r_emit;
                o_cmd.emit      = 1'b1;
                if (r_emit == LAST_IDX) begin
                    o_cmd.emit_last = 1'b1;
                    n_emit          = '0;
                    n_state         = S_IDLE;
                end else begin
                    n_emit = r_emit + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/odd_even_merge_sorter.sv
// top level of the odd-even merge sorter
`default_nettype none

// Sorts sets of ELEMENT_COUNT signed 32-bit words in ascending order.
// Input channel: a word is taken at a rising edge with start high and busy
// low. Words are loaded one per cycle into the element ram while busy is low.
// The edge that takes the last word of a set raises busy; the controller then
// steps through the odd-even merge network one comparator at a time.
// Each comparator passes four states (check, read, compare and write the lower
// word, write the upper word) because the element ram has one write port;
// a network slot that holds no comparator takes only the check state.
// Then the set leaves in consecutive cycles, one word per cycle on
// o_value_out with o_valid high, o_last_out high on the final word.
// The first result appears in the cycle after emission starts (registered read).
// For ELEMENT_COUNT = 8 the network holds 19 comparators and one empty slot.
// busy falls with the final word on the outputs; the next set may load then.
// The receiver cannot stall: results are valid for exactly one cycle.
// Reset (synchronous, active low) clears the load count and the controller;
// the element ram holds no reset value and needs none.

module odd_even_merge_sorter
    import oems_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] i_value_in,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_value_out,
    output logic                          o_last_out
);

    t_dp_cmd cmd;

    oems_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    oems_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .o_value_out (o_value_out),
        .o_last_out  (o_last_out)
    );

    // an accepted word is written to the ram in the same cycle
    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> (cmd.wr_en && cmd.wr_sel == WR_LOAD))
        else $error("accepted word not written");

    // lower write of a compare-exchange is always followed by the upper one
    a_pair_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_en && cmd.wr_sel == WR_MIN) |=> (cmd.wr_en && cmd.wr_sel == WR_MAX))
        else $error("compare-exchange write-back broken");

    // results of a set leave in consecutive cycles
    a_emit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_out) |=> o_valid)
        else $error("gap inside sorted set");

    // nothing follows the final word of a set directly
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |=> !o_valid)
        else $error("word after final word");

endmodule

`default_nettype wire
